>>> src/asfp_pkg.sv
// Shared constants and types for the air sensor frame parser.
`default_nettype none

package asfp_pkg;

  // Frame syntax bytes.
  localparam logic [7:0] HDR_BYTE      = 8'h16;
  localparam logic [7:0] MODE_READINGS = 8'h01;
  localparam logic [7:0] MODE_DUST     = 8'h0C;
  localparam logic [7:0] DUST_OFF      = 8'h01;

  // Payload bytes kept per frame, and the temperature offset in tenths.
  localparam int unsigned KEPT_BYTES  = 10;
  localparam logic [16:0] TEMP_OFFSET = 17'd500;

  // Width of the packed result beat.
  localparam int unsigned RESULT_BITS = 82;
  localparam int unsigned TDATA_BITS  = 88;

  // Frame completion event from the parser, with the payload including this beat.
  typedef struct packed {
    logic                            done;
    logic [7:0]                      mode;
    logic [KEPT_BYTES-1:0][7:0]      data;
  } asfp_frame_t;

endpackage

`default_nettype wire

>>> src/asfp_parser.sv
// Byte-level frame parser: header, length, mode and payload collection.
`default_nettype none

module asfp_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [7:0]          rx_byte,
  output logic                     last_payload,
  output asfp_pkg::asfp_frame_t    frame
);
  import asfp_pkg::*;

  typedef enum logic [1:0] {
    WAIT_HDR = 2'd0,
    GET_LEN  = 2'd1,
    GET_MODE = 2'd2,
    PAYLOAD  = 2'd3
  } phase_t;

  phase_t                      phase;
  logic [7:0]                  frame_length;
  logic [7:0]                  frame_kind;
  logic [7:0]                  payload_count;
  logic [KEPT_BYTES-1:0][7:0]  payload_bytes;
  logic [7:0]                  count_next;

  // The count after this payload beat decides whether the frame ends.
  assign count_next   = payload_count + 8'd1;
  assign last_payload = (phase == PAYLOAD) && (count_next >= frame_length);

  // Payload as it stands once the current beat is written.
  always_comb begin
    frame.done = take && last_payload;
    frame.mode = frame_kind;
    for (int i = 0; i < KEPT_BYTES; i++) begin
      if ((phase == PAYLOAD) && (payload_count == 8'(i))) begin
        frame.data[i] = rx_byte;
      end else begin
        frame.data[i] = payload_bytes[i];
      end
    end
  end

  // Payload store: each kept position is written only while counting through it.
  always_ff @(posedge clk) begin
    if (take && (phase == PAYLOAD) && (payload_count < 8'(KEPT_BYTES))) begin
      payload_bytes[payload_count[$clog2(KEPT_BYTES)-1:0]] <= rx_byte;
    end
  end

  // Phase sequencing and frame header fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= WAIT_HDR;
      frame_length  <= 8'd0;
      frame_kind    <= 8'hFF;
      payload_count <= 8'd0;
    end else if (take) begin
      case (phase)
        WAIT_HDR: begin
          if (rx_byte == HDR_BYTE) begin
            phase <= GET_LEN;
          end
        end
        GET_LEN: begin
          frame_length <= rx_byte;
          phase        <= GET_MODE;
        end
        GET_MODE: begin
          frame_kind <= rx_byte;
          phase      <= PAYLOAD;
        end
        PAYLOAD: begin
          if (last_payload) begin
            phase         <= WAIT_HDR;
            payload_count <= 8'd0;
          end else begin
            payload_count <= count_next;
          end
        end
        default: begin
          phase <= WAIT_HDR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/air_sensor_frame_parser.sv
// Top level of the air sensor frame parser: held readings and the result register.
`default_nettype none

// Accepts one received serial byte per beat on the s_ side and emits one result
// beat on the m_ side for every completed frame (header 0x16, length, mode, then at
// least one payload byte). Each byte is handled in the cycle it is accepted, so a
// byte can be taken every clock cycle; the result appears in the output register
// in the cycle after the frame's last payload byte. Input is held off only when the
// byte would finish a frame while the previous result beat is still waiting to be
// taken. Mode 0x01 updates the held readings, mode 0x0C updates the PM2.5 switch,
// and every result beat carries the mode and all held values.
module air_sensor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Received byte: [7:0] rx_byte.
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Result: [7:0] frame_mode, [23:8] co2_ppm, [31:24] voc_level,
  // [47:32] humidity_tenths, [64:48] temperature_tenths, [80:65] pm25_value,
  // [81] pm25_enabled, [87:82] zero.
  output logic [asfp_pkg::TDATA_BITS-1:0] m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready
);
  import asfp_pkg::*;

  asfp_frame_t  frame;
  logic         last_payload;
  logic         take;
  logic         out_free;

  logic [15:0]  held_co2, held_co2_next;
  logic [7:0]   held_voc, held_voc_next;
  logic [15:0]  held_humidity, held_humidity_next;
  logic [16:0]  held_temperature, held_temperature_next;
  logic [15:0]  held_pm25, held_pm25_next;
  logic         held_pm25_on, held_pm25_on_next;

  // A byte that ends a frame needs a free result register; others never wait.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = out_free || !last_payload;
  assign take     = s_tvalid && s_tready;

  asfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (s_tdata),
    .last_payload (last_payload),
    .frame        (frame)
  );

  // Held values after the completing frame, chosen by its mode.
  always_comb begin
    held_co2_next         = held_co2;
    held_voc_next         = held_voc;
    held_humidity_next    = held_humidity;
    held_temperature_next = held_temperature;
    held_pm25_next        = held_pm25;
    held_pm25_on_next     = held_pm25_on;
    if (frame.mode == MODE_READINGS) begin
      held_co2_next         = {frame.data[0], frame.data[1]};
      held_voc_next         = frame.data[3];
      held_humidity_next    = {frame.data[4], frame.data[5]};
      held_temperature_next = {1'b0, frame.data[6], frame.data[7]} - TEMP_OFFSET;
      held_pm25_next        = {frame.data[8], frame.data[9]};
    end else if (frame.mode == MODE_DUST) begin
      held_pm25_on_next = (frame.data[0] != DUST_OFF);
    end
  end

  // Held readings update once per completed frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_co2         <= 16'd0;
      held_voc         <= 8'd0;
      held_humidity    <= 16'd0;
      held_temperature <= 17'd0;
      held_pm25        <= 16'd0;
      held_pm25_on     <= 1'b1;
    end else if (frame.done) begin
      held_co2         <= held_co2_next;
      held_voc         <= held_voc_next;
      held_humidity    <= held_humidity_next;
      held_temperature <= held_temperature_next;
      held_pm25        <= held_pm25_next;
      held_pm25_on     <= held_pm25_on_next;
    end
  end

  // Result register: loaded on frame completion, cleared when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (frame.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      m_tdata <= {{(TDATA_BITS-RESULT_BITS){1'b0}}, held_pm25_on_next, held_pm25_next,
                  held_temperature_next, held_humidity_next, held_voc_next,
                  held_co2_next, frame.mode};
    end
  end

  // A completed frame always shows up as a result beat in the next cycle.
  assert property (@(posedge clk) disable iff (rst) frame.done |=> m_tvalid)
    else $error("completed frame did not load the result register");

  // A frame-ending byte is never taken while a result beat is stalled.
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready && last_payload) |-> !s_tready)
    else $error("frame end accepted over a stalled result");

  // A new result beat only follows an accepted frame-ending byte.
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !$past(m_tvalid && !m_tready) && !$past(rst))
                   |-> $past(take && last_payload))
    else $error("result beat without a completed frame");

endmodule

`default_nettype wire

>>> tb/asfp_checker.sv
// Checker for the air sensor frame parser: predicts each result beat and compares it.
module asfp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      s_tdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [asfp_pkg::TDATA_BITS-1:0] m_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import asfp_pkg::*;

  typedef enum logic [1:0] {
    WAIT_HDR,
    TAKE_LEN,
    TAKE_MODE,
    TAKE_PAYLOAD
  } parse_phase_e;

  // One result beat as the parser should report it.
  typedef struct packed {
    logic [7:0]  mode;
    logic [15:0] co2;
    logic [7:0]  voc;
    logic [15:0] humidity;
    logic [16:0] temperature;
    logic [15:0] pm25;
    logic        pm25_on;
  } sensor_report_t;

  parse_phase_e   phase;
  logic [7:0]     frame_len;
  logic [7:0]     frame_kind;
  logic [7:0]     byte_count;
  logic [7:0]     kept [KEPT_BYTES];
  sensor_report_t held;
  sensor_report_t reports_due [$];

  // Big-endian 16-bit word from two kept payload bytes.
  function automatic logic [15:0] word_at(input int hi);
    return {kept[hi], kept[hi+1]};
  endfunction

  // Advance the frame parser by one received byte.
  task automatic absorb_byte(input logic [7:0] b);
    case (phase)
      WAIT_HDR: begin
        if (b == HDR_BYTE) phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        frame_len = b;
        phase = TAKE_MODE;
      end
      TAKE_MODE: begin
        frame_kind = b;
        phase = TAKE_PAYLOAD;
      end
      default: begin
        if (byte_count < KEPT_BYTES) kept[byte_count] = b;
        byte_count = byte_count + 8'd1;
        // A zero length still ends after the first payload byte.
        if (byte_count >= frame_len) begin
          phase = WAIT_HDR;
          byte_count = '0;
          if (frame_kind == MODE_READINGS) begin
            held.co2         = word_at(0);
            held.voc         = kept[3];
            held.humidity    = word_at(4);
            held.temperature = {1'b0, word_at(6)} - TEMP_OFFSET;
            held.pm25        = word_at(8);
          end else if (frame_kind == MODE_DUST) begin
            held.pm25_on = (kept[0] != DUST_OFF);
          end
          held.mode = frame_kind;
          reports_due.push_back(held);
        end
      end
    endcase
  endtask

  task automatic field_check(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare one result beat with the oldest predicted report.
  task automatic check_report(input logic [TDATA_BITS-1:0] d);
    sensor_report_t want;
    if (reports_due.size() == 0) begin
      $error("result beat with no completed frame pending: 0x%0h", d);
      fail_count++;
    end else begin
      want = reports_due.pop_front();
      field_check("frame_mode", 17'(want.mode), 17'(d[7:0]));
      field_check("co2_ppm", 17'(want.co2), 17'(d[23:8]));
      field_check("voc_level", 17'(want.voc), 17'(d[31:24]));
      field_check("humidity_tenths", 17'(want.humidity), 17'(d[47:32]));
      field_check("temperature_tenths", want.temperature, d[64:48]);
      field_check("pm25_value", 17'(want.pm25), 17'(d[80:65]));
      field_check("pm25_enabled", 17'(want.pm25_on), 17'(d[81]));
      field_check("padding", 17'd0, 17'(d[87:82]));
      results_checked++;
    end
  endtask

  // Sample both channels at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      phase = WAIT_HDR;
      frame_len = '0;
      frame_kind = 8'hFF;
      byte_count = '0;
      for (int i = 0; i < KEPT_BYTES; i++) kept[i] = '0;
      held = '0;
      held.mode = 8'hFF;
      held.pm25_on = 1'b1;
      reports_due.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (m_tvalid && m_tready) check_report(m_tdata);
      if (s_tvalid && s_tready) absorb_byte(s_tdata);
    end
    pending = reports_due.size();
  end

endmodule

>>> tb/air_sensor_frame_parser_tb.sv
// Testbench top for the air sensor frame parser: clock, reset, byte stimulus and verdict.
module air_sensor_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asfp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [7:0]            s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  quiet = 1'b0;

  int fail_count;
  int pending;
  int results_checked;
  int framed_bytes = 0;
  int frames_offered = 0;
  int idle_cycles = 0;
  logic [7:0] payload_q [$];

  air_sensor_frame_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  asfp_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_tdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: random back-pressure except during the quiet stretch.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 33);
  end

  // Watchdog on cycles where no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one byte, with random gaps ahead of it, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tdata <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Header, length, mode, then the payload: leading bytes come from payload_q,
  // the rest are random. Dropping bytes leaves the frame open for what follows.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] mode,
                            input bit broken);
    int n;
    n = (len == 0) ? 1 : int'(len);
    if (broken) n = n - $urandom_range(1, n);
    send_byte(HDR_BYTE);
    send_byte(len);
    send_byte(mode);
    for (int i = 0; i < n; i++)
      send_byte((payload_q.size() != 0) ? payload_q.pop_front() : 8'($urandom));
    payload_q.delete();
    framed_bytes += n + 3;
    frames_offered++;
  endtask

  initial begin
    int start_bytes;
    int roll;
    int pick;
    logic [7:0] len;
    logic [7:0] mode;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Bytes that are not a header are dropped while hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h15);
    send_byte(8'h17);
    // Full readings frames first, so every kept byte is written before any
    // short frame reads it. All zeros gives the lowest temperature.
    repeat (10) payload_q.push_back(8'h00);
    send_frame(8'd10, MODE_READINGS, 1'b0);
    repeat (10) payload_q.push_back(8'hFF);
    send_frame(8'd10, MODE_READINGS, 1'b0);
    // Dust switch off, then on through a zero-length frame.
    payload_q.push_back(DUST_OFF);
    send_frame(8'd1, MODE_DUST, 1'b0);
    payload_q.push_back(8'h00);
    send_frame(8'd0, MODE_DUST, 1'b0);
    payload_q.push_back(8'hFE);
    send_frame(8'd2, MODE_DUST, 1'b0);
    // Payload past the kept bytes, and a short frame keeping older bytes.
    send_frame(8'd12, MODE_READINGS, 1'b0);
    send_frame(8'd3, MODE_READINGS, 1'b0);
    // Header value used as length, mode and payload inside a frame.
    repeat (3) payload_q.push_back(HDR_BYTE);
    send_frame(HDR_BYTE, HDR_BYTE, 1'b0);
    send_frame(8'd2, 8'h00, 1'b0);
    send_frame(8'd255, 8'hFF, 1'b0);
    // A frame cut short swallows the next header as payload.
    send_frame(8'd5, MODE_READINGS, 1'b1);
    send_frame(8'd4, MODE_READINGS, 1'b0);
    send_frame(8'd10, MODE_READINGS, 1'b0);

    // Random part: mostly well-formed frames, some noise and cut frames.
    start_bytes = framed_bytes;
    while (framed_bytes - start_bytes < RANDOM_BYTES) begin
      quiet <= (frames_offered >= 30 && frames_offered < 50);
      roll = $urandom_range(99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) len = 8'($urandom_range(0, 12));
        else if (pick < 95) len = 8'($urandom_range(13, 40));
        else len = 8'($urandom_range(41, 255));
        pick = $urandom_range(99);
        if (pick < 40) begin
          mode = MODE_READINGS;
        end else if (pick < 65) begin
          mode = MODE_DUST;
          payload_q.push_back($urandom_range(1) ? DUST_OFF : 8'($urandom));
        end else begin
          mode = 8'($urandom);
        end
        if ($urandom_range(99) < 5) payload_q.push_back(HDR_BYTE);
        send_frame(len, mode, roll < 18);
      end
    end
    s_tvalid <= 1'b0;
    quiet <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles.
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Offered %0d frames in %0d framed bytes, plus header hunting noise.",
             frames_offered, framed_bytes);
    $display("Checked %0d result beats under random gaps and back-pressure.",
             results_checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/asfp_pkg.sv
src/asfp_parser.sv
src/air_sensor_frame_parser.sv
tb/asfp_checker.sv
tb/air_sensor_frame_parser_tb.sv
